// File: hdl/mits_pkg.sv
// shared types, codes and layout constants for the message id table search
package mits_pkg;

    localparam int unsigned ID_W      = 32;
    localparam int unsigned POS_W     = 11;
    localparam int unsigned MPOS_W    = 10;
    localparam int unsigned OFF_W     = 26;
    localparam int unsigned CNT16_W   = 16;
    localparam int unsigned FORM_W    = 3;
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned CFG_DAT_W = 16;

    // request types
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT_FORM = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_COUNT    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INFO_COUNT  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_SIZE  = 4'd3;

    // layout forms: group bits / index bits
    localparam logic [FORM_W-1:0] FORM_G32_I0 = 3'd0;
    localparam logic [FORM_W-1:0] FORM_G24_I8 = 3'd1;
    localparam logic [FORM_W-1:0] FORM_G16_I16 = 3'd2;
    localparam logic [FORM_W-1:0] FORM_G8_I24 = 3'd3;
    localparam logic [FORM_W-1:0] FORM_G0_I32 = 3'd4;

    localparam logic [ID_W-1:0] MASK_ALL  = 32'hFFFF_FFFF;
    localparam logic [ID_W-1:0] MASK_G24  = 32'hFFFF_FF00;
    localparam logic [ID_W-1:0] MASK_I8   = 32'h0000_00FF;
    localparam logic [ID_W-1:0] MASK_G16  = 32'hFFFF_0000;
    localparam logic [ID_W-1:0] MASK_I16  = 32'h0000_FFFF;
    localparam logic [ID_W-1:0] MASK_G8   = 32'hFF00_0000;
    localparam logic [ID_W-1:0] MASK_I24  = 32'h00FF_FFFF;

    typedef struct packed {
        logic load_we;
        logic q_init;
        logic scan;
        logic resolve;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic exhausted;
    } t_dp_stat;

    // true when the stored id splits into the sought group and index
    function automatic logic id_match(
        input logic [ID_W-1:0]   id,
        input logic [FORM_W-1:0] form,
        input logic [ID_W-1:0]   qg,
        input logic [ID_W-1:0]   qi
    );
        logic [ID_W-1:0] grp;
        logic [ID_W-1:0] idx;
        case (form)
            FORM_G32_I0: begin
                grp = id & MASK_ALL;
                idx = '0;
            end
            FORM_G24_I8: begin
                grp = (id & MASK_G24) >> 8;
                idx = id & MASK_I8;
            end
            FORM_G16_I16: begin
                grp = (id & MASK_G16) >> 16;
                idx = id & MASK_I16;
            end
            FORM_G8_I24: begin
                grp = (id & MASK_G8) >> 24;
                idx = id & MASK_I24;
            end
            default: begin
                // all index, also the unused codes
                grp = '0;
                idx = id & MASK_ALL;
            end
        endcase
        return (grp == qg) && (idx == qi);
    endfunction

endpackage

// File: hdl/mits_dp.sv
// datapath: id memory, config registers, scan counter, compare and offset multiply
module mits_dp #(
    parameter int unsigned ID_DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mits_pkg::t_dp_cmd                   i_cmd,
    output mits_pkg::t_dp_stat                  o_stat,
    input  logic                                i_cfg_we,
    input  logic [mits_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mits_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    input  logic [9:0]                          i_load_slot,
    input  logic [mits_pkg::ID_W-1:0]           i_load_id,
    input  logic [mits_pkg::ID_W-1:0]           i_query_group,
    input  logic [mits_pkg::ID_W-1:0]           i_query_index,
    output logic                                o_found,
    output logic [mits_pkg::MPOS_W-1:0]         o_match_position,
    output logic [mits_pkg::OFF_W-1:0]          o_entry_offset,
    output logic                                o_out_of_range
);

    localparam int unsigned AW = (ID_DEPTH > 1) ? $clog2(ID_DEPTH) : 1;

    logic [mits_pkg::ID_W-1:0]    r_mem [ID_DEPTH];
    logic [mits_pkg::ID_W-1:0]    r_rd_data;
    logic [mits_pkg::POS_W-1:0]   r_rd_pos;
    logic                         r_rd_vld;
    logic [mits_pkg::POS_W-1:0]   r_pos;
    logic [mits_pkg::POS_W-1:0]   r_limit;
    logic [mits_pkg::POS_W-1:0]   n_limit;
    logic [mits_pkg::ID_W-1:0]    r_held_group;
    logic [mits_pkg::ID_W-1:0]    r_held_index;
    logic                         r_found;
    logic [mits_pkg::POS_W-1:0]   r_mpos;

    logic [mits_pkg::FORM_W-1:0]  r_layout_form;
    logic [mits_pkg::POS_W-1:0]   r_id_count;
    logic [mits_pkg::CNT16_W-1:0] r_info_count;
    logic [mits_pkg::CNT16_W-1:0] r_entry_size;

    logic slot_ok;
    logic issue;

    assign slot_ok = 32'(i_load_slot) < ID_DEPTH;
    assign issue   = i_cmd.scan && (r_pos < r_limit);
    assign n_limit = (32'(r_id_count) > ID_DEPTH) ? 11'(ID_DEPTH) : r_id_count;

    assign o_stat.hit = r_rd_vld &&
        mits_pkg::id_match(r_rd_data, r_layout_form, r_held_group, r_held_index);
    assign o_stat.exhausted = !r_rd_vld && (r_pos >= r_limit);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout_form <= '0;
            r_id_count    <= '0;
            r_info_count  <= '0;
            r_entry_size  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mits_pkg::CFG_LAYOUT_FORM: r_layout_form <= i_cfg_data[mits_pkg::FORM_W-1:0];
                mits_pkg::CFG_ID_COUNT:    r_id_count    <= i_cfg_data[mits_pkg::POS_W-1:0];
                mits_pkg::CFG_INFO_COUNT:  r_info_count  <= i_cfg_data;
                mits_pkg::CFG_ENTRY_SIZE:  r_entry_size  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // id memory, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we && slot_ok) begin
            r_mem[AW'(i_load_slot)] <= i_load_id;
        end
        if (issue) begin
            r_rd_data <= r_mem[AW'(r_pos)];
        end
    end

    // scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_limit      <= '0;
            r_rd_vld     <= 1'b0;
            r_rd_pos     <= '0;
            r_held_group <= '0;
            r_held_index <= '0;
            r_found      <= 1'b0;
            r_mpos       <= '0;
        end else begin
            if (i_cmd.q_init) begin
                r_pos        <= '0;
                r_limit      <= n_limit;
                r_rd_vld     <= 1'b0;
                r_held_group <= i_query_group;
                r_held_index <= i_query_index;
            end else begin
                r_rd_vld <= issue;
                if (issue) begin
                    r_rd_pos <= r_pos;
                    r_pos    <= r_pos + 1'b1;
                end
            end
            if (i_cmd.resolve) begin
                r_found <= o_stat.hit;
                r_mpos  <= o_stat.hit ? r_rd_pos : '0;
            end
        end
    end

    // result registers, offset product registered here
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_found          <= r_found;
            o_match_position <= r_mpos[mits_pkg::MPOS_W-1:0];
            o_entry_offset   <= 26'(r_entry_size) * 26'(r_mpos[mits_pkg::MPOS_W-1:0]);
            o_out_of_range   <= r_found && (16'(r_mpos) >= r_info_count);
        end
    end

endmodule

// File: hdl/mits_ctrl.sv
// controller state machine for load and query sequencing
module mits_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_req_type,
    input  mits_pkg::t_dp_stat  i_stat,
    output mits_pkg::t_dp_cmd   o_cmd,
    output logic                o_busy,
    output logic                o_done
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_CALC} t_state;

    t_state r_state;
    t_state n_state;
    logic   r_done;
    logic   n_done;
    logic   accept;

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign accept = i_start && !o_busy;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req_type == mits_pkg::REQ_QUERY) begin
                        o_cmd.q_init = 1'b1;
                        n_state      = S_SCAN;
                    end else begin
                        o_cmd.load_we = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.hit || i_stat.exhausted) begin
                    o_cmd.resolve = 1'b1;
                    n_state       = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.finish = 1'b1;
                n_done       = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    a_query_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req_type == mits_pkg::REQ_QUERY) |=> o_busy)
        else $error("query accepted but block not busy");

    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req_type == mits_pkg::REQ_LOAD) |=> !o_busy)
        else $error("load left block busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_done_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobe while still busy");

endmodule

// File: hdl/message_id_table_search.sv
// top level of the message id table search
// load beat: written in the accept cycle, busy never rises, next beat the cycle after
// query beat: result strobe once the scan hits an entry or all L entries miss,
//   L = min(id_count, ID_DEPTH), one memory read per cycle
// busy drops in the strobe cycle, so a new beat can start there; receiver cannot stall
// reset (i_rst_n low, synchronous) clears config registers and control; table is not cleared
module message_id_table_search #(
    parameter int unsigned ID_DEPTH = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command side
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_req_type,
    input  logic [9:0]                      i_load_slot,
    input  logic [mits_pkg::ID_W-1:0]       i_load_id,
    input  logic [mits_pkg::ID_W-1:0]       i_query_group,
    input  logic [mits_pkg::ID_W-1:0]       i_query_index,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mits_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mits_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    // result side, one beat per query
    output logic                            o_done,
    output logic                            o_found,
    output logic [mits_pkg::MPOS_W-1:0]     o_match_position,
    output logic [mits_pkg::OFF_W-1:0]      o_entry_offset,
    output logic                            o_out_of_range
);

    mits_pkg::t_dp_cmd  cmd;
    mits_pkg::t_dp_stat stat;

    // user must keep config writes to idle; not checked here, channel never pushes back
    assign o_cfg_ready = 1'b1;

    // sequencing: idle, scan until hit or table end, then offset multiply
    mits_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (busy),
        .o_done     (o_done)
    );

    // storage, compare against the held query, result registers
    mits_dp #(
        .ID_DEPTH (ID_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_load_slot      (i_load_slot),
        .i_load_id        (i_load_id),
        .i_query_group    (i_query_group),
        .i_query_index    (i_query_index),
        .o_found          (o_found),
        .o_match_position (o_match_position),
        .o_entry_offset   (o_entry_offset),
        .o_out_of_range   (o_out_of_range)
    );

endmodule
